// ===== hw/rtl/aba_pkg.sv =====
// ----------------------------------------------------------------------------
// aba_pkg: shared types and constants of the aligned block allocator
// Word formats, slot map codes, command and status codes, control states.
// ----------------------------------------------------------------------------
package aba_pkg;

  // Default sizing of the slot map
  localparam int NUM_SLOTS_DEF       = 1024;
  localparam int SLOT_BYTES_DEF      = 32;
  localparam int MAX_ALLOC_BYTES_DEF = 2048;

  // Field widths
  localparam int LEN_W = 13;
  localparam int IDX_W = 10;
  localparam int POS_W = 4;   // holds a bit position of a length word

  // Slot map layout: WORD_SLOTS slots of SLOT_W bits in one memory word
  localparam int SLOT_W     = 2;
  localparam int WORD_SLOTS = 32;
  localparam int WS_LOG     = $clog2(WORD_SLOTS);
  localparam int KSEL_W     = $clog2(WS_LOG + 1);

  localparam logic [SLOT_W-1:0] SLOT_UNUSED = 2'd0;
  localparam logic [SLOT_W-1:0] SLOT_USED   = 2'd1;
  localparam logic [SLOT_W-1:0] SLOT_CONT   = 2'd2;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef struct packed {
    logic             cmd;
    logic [LEN_W-1:0] length_bytes;
    logic [IDX_W-1:0] slot_index;
  } in_word_t;

  typedef struct packed {
    logic             status;
    logic [IDX_W-1:0] result_index;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_MARK,
    ST_DONE
  } state_t;

endpackage

// ===== hw/rtl/aligned_block_allocator.sv =====
// ----------------------------------------------------------------------------
// aligned_block_allocator: power-of-two aligned run allocator over a slot map
// Steps: a bad request goes straight from accept to the done state. Allocate reads one map word
//   (32 slots) a cycle from word 0, free from the word of slot_index on, until the scan
//   ends; a run of n slots wider than a word is then written as n/32 map words.
// Requests: one at a time; in_ready stays low until the result word is loaded.
// Reset: a clearing pass writes NUM_SLOTS/32 words with in_ready low.
// ----------------------------------------------------------------------------
module aligned_block_allocator #(
  parameter int NUM_SLOTS       = aba_pkg::NUM_SLOTS_DEF,
  parameter int SLOT_BYTES      = aba_pkg::SLOT_BYTES_DEF,
  parameter int MAX_ALLOC_BYTES = aba_pkg::MAX_ALLOC_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  aba_pkg::in_word_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output aba_pkg::out_word_t out_data
);

  localparam int WS         = aba_pkg::WORD_SLOTS;
  localparam int WS_LOG     = aba_pkg::WS_LOG;
  localparam int SW         = aba_pkg::SLOT_W;
  localparam int WORD_W     = WS * SW;
  localparam int NUM_WORDS  = (NUM_SLOTS + WS - 1) / WS;
  localparam int WADDR_W    = $clog2(NUM_WORDS);
  localparam int WCNT_W     = $clog2(NUM_WORDS + 1);
  localparam int SLOT_SHIFT = $clog2(SLOT_BYTES);
  localparam int POS_W      = aba_pkg::POS_W;
  localparam int LEN_W      = aba_pkg::LEN_W;
  localparam int IDX_W      = aba_pkg::IDX_W;
  localparam int KSEL_W     = aba_pkg::KSEL_W;

  localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(NUM_WORDS - 1);
  localparam logic [WORD_W-1:0]  WORD_CONT = {WS{aba_pkg::SLOT_CONT}};
  localparam logic [WORD_W-1:0]  WORD_HEAD = {{(WS-1){aba_pkg::SLOT_CONT}},
                                              aba_pkg::SLOT_USED};

  // --------------------------------------------------------------------------
  // Control and request registers
  // --------------------------------------------------------------------------
  aba_pkg::state_t    state_r, state_nxt;
  logic               cmd_r, cmd_nxt;
  logic [POS_W-1:0]   k_r, k_nxt;            // log2 of the run length in slots
  logic [IDX_W-1:0]   idx_r, idx_nxt;        // start slot of a free
  logic [WCNT_W-1:0]  iss_r, iss_nxt;        // next map word to read
  logic               dvld_r, dvld_nxt;      // read data is for a scan word
  logic [WADDR_W-1:0] dword_r, dword_nxt;    // word that the read data holds
  logic               run_ok_r, run_ok_nxt;  // multi-word run still free
  logic [WADDR_W-1:0] gstart_r, gstart_nxt;  // first word of current group
  logic [WADDR_W-1:0] addr_r, addr_nxt;      // clear / mark write pointer
  logic [WADDR_W-1:0] mark_end_r, mark_end_nxt;
  aba_pkg::out_word_t res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  aba_pkg::out_word_t out_data_r, out_data_nxt;

  // Map memory ports
  logic               wr_en, rd_en;
  logic [WADDR_W-1:0] wr_addr;
  logic [WORD_W-1:0]  wr_data, rd_data;

  aba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_WORDS)
  ) u_map (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (WADDR_W'(iss_r)),
    .rd_data (rd_data)
  );

  // --------------------------------------------------------------------------
  // Request check at accept
  // --------------------------------------------------------------------------
  logic             in_acc;
  logic [LEN_W-1:0] len;
  logic [POS_W-1:0] len_pos;
  logic [POS_W-1:0] k_in;
  logic             len_ok, idx_ok, req_bad;

  assign in_acc = in_valid && in_ready;
  assign len    = in_data.length_bytes;

  // Length is one-hot when it passes, so the set bit gives log2
  always_comb begin
    len_pos = '0;
    for (int b = 0; b < LEN_W; b++) begin
      if (len[b]) begin
        len_pos = POS_W'(b);
      end
    end
  end

  always_comb begin
    k_in   = POS_W'(32'(len_pos) - 32'(SLOT_SHIFT));
    len_ok = (32'(len) >= 32'(SLOT_BYTES)) && (32'(len) <= 32'(MAX_ALLOC_BYTES)) &&
             ((len & (len - LEN_W'(1))) == '0) &&
             ((32'd1 << k_in) <= 32'(NUM_SLOTS));
    idx_ok  = 32'(in_data.slot_index) < 32'(NUM_SLOTS);
    req_bad = (in_data.cmd == aba_pkg::CMD_ALLOC) ? !len_ok : !idx_ok;
  end

  // --------------------------------------------------------------------------
  // Decode the word under scan; slots past the map end are neither free
  // nor continue, so runs never reach past it and a free chain stops there
  // --------------------------------------------------------------------------
  logic [WS-1:0] free_v, cont_v;

  always_comb begin
    for (int j = 0; j < WS; j++) begin
      free_v[j] = (((32'(dword_r) << WS_LOG) + 32'(j)) < 32'(NUM_SLOTS)) &&
                  (rd_data[SW*j +: SW] == aba_pkg::SLOT_UNUSED);
      cont_v[j] = (((32'(dword_r) << WS_LOG) + 32'(j)) < 32'(NUM_SLOTS)) &&
                  (rd_data[SW*j +: SW] == aba_pkg::SLOT_CONT);
    end
  end

  // Aligned group free tree: level L tells whether each run of 2^L is free
  logic [WS_LOG:0][WS-1:0] lvl;
  logic [KSEL_W-1:0]       ksel;
  logic                    is_small;
  logic [WS-1:0]           grp;

  assign ksel     = k_r[KSEL_W-1:0];
  assign is_small = k_r <= POS_W'(WS_LOG);

  always_comb begin
    lvl[0] = free_v;
    for (int l = 1; l <= WS_LOG; l++) begin
      for (int g = 0; g < WS; g++) begin
        if (g < (WS >> l)) begin
          lvl[l][g] = lvl[l-1][2*g] & lvl[l-1][2*g+1];
        end else begin
          lvl[l][g] = 1'b0;
        end
      end
    end
    grp = is_small ? lvl[ksel] : '0;
  end

  // First free group inside the word, and the word with that run marked
  logic [WS_LOG-1:0] gsel, j0;
  logic [WS_LOG:0]   n_small, j_end;
  logic              grp_hit;
  logic [WORD_W-1:0] alloc_word;

  always_comb begin
    gsel = '0;
    for (int g = WS - 1; g >= 0; g--) begin
      if (grp[g]) begin
        gsel = WS_LOG'(g);
      end
    end
    grp_hit = |grp;
    j0      = WS_LOG'(32'(gsel) << ksel);
    n_small = (WS_LOG+1)'(32'd1 << ksel);
    j_end   = {1'b0, j0} + n_small;
    for (int j = 0; j < WS; j++) begin
      if (WS_LOG'(j) == j0) begin
        alloc_word[SW*j +: SW] = aba_pkg::SLOT_USED;
      end else if ((WS_LOG'(j) > j0) && ((WS_LOG+1)'(j) < j_end)) begin
        alloc_word[SW*j +: SW] = aba_pkg::SLOT_CONT;
      end else begin
        alloc_word[SW*j +: SW] = rd_data[SW*j +: SW];
      end
    end
  end

  // Free chain: clear from the start slot (or word start) up to the first
  // slot that is not a continue slot
  logic [WADDR_W-1:0] free_sw;
  logic [WS_LOG-1:0]  fp;
  logic               first_w, free_hit;
  logic [WS-1:0]      stop_cand;
  logic [WS_LOG:0]    stop_pos, lo_pos;
  logic [WORD_W-1:0]  free_word;

  assign free_sw = WADDR_W'(idx_r >> WS_LOG);
  assign fp      = idx_r[WS_LOG-1:0];
  assign first_w = dword_r == free_sw;

  always_comb begin
    for (int j = 0; j < WS; j++) begin
      stop_cand[j] = !cont_v[j] && (!first_w || (WS_LOG'(j) > fp));
    end
    stop_pos = (WS_LOG+1)'(WS);
    for (int j = WS - 1; j >= 0; j--) begin
      if (stop_cand[j]) begin
        stop_pos = (WS_LOG+1)'(j);
      end
    end
    free_hit = |stop_cand;
    lo_pos   = first_w ? {1'b0, fp} : '0;
    for (int j = 0; j < WS; j++) begin
      if (((WS_LOG+1)'(j) >= lo_pos) && ((WS_LOG+1)'(j) < stop_pos)) begin
        free_word[SW*j +: SW] = aba_pkg::SLOT_UNUSED;
      end else begin
        free_word[SW*j +: SW] = rd_data[SW*j +: SW];
      end
    end
  end

  // Multi-word runs: a group of 2^(k-5) words starting on a group boundary
  logic [POS_W-1:0]   gsh;
  logic [WADDR_W-1:0] gmask;
  logic               gfirst, glast, run_ok_now;
  logic [WADDR_W-1:0] gstart_now;

  always_comb begin
    gsh        = k_r - POS_W'(WS_LOG);
    gmask      = WADDR_W'((32'd1 << gsh) - 32'd1);
    gfirst     = (dword_r & gmask) == '0;
    glast      = (dword_r & gmask) == gmask;
    run_ok_now = (gfirst || run_ok_r) && (&free_v);
    gstart_now = gfirst ? dword_r : gstart_r;
  end

  // Scan events
  logic proc, last_w, small_found, big_found, alloc_miss, free_end, out_free;

  always_comb begin
    proc        = (state_r == aba_pkg::ST_SCAN) && dvld_r;
    last_w      = dword_r == LAST_WORD;
    small_found = proc && (cmd_r == aba_pkg::CMD_ALLOC) && is_small && grp_hit;
    big_found   = proc && (cmd_r == aba_pkg::CMD_ALLOC) && !is_small &&
                  glast && run_ok_now;
    alloc_miss  = proc && (cmd_r == aba_pkg::CMD_ALLOC) && last_w &&
                  !small_found && !big_found;
    free_end    = proc && (cmd_r == aba_pkg::CMD_FREE) && (free_hit || last_w);
    out_free    = !out_valid_r || out_ready;
  end

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      aba_pkg::ST_CLEAR: begin
        if (addr_r == LAST_WORD) begin
          state_nxt = aba_pkg::ST_IDLE;
        end
      end
      aba_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = req_bad ? aba_pkg::ST_DONE : aba_pkg::ST_SCAN;
        end
      end
      aba_pkg::ST_SCAN: begin
        if (big_found) begin
          state_nxt = aba_pkg::ST_MARK;
        end else if (small_found || alloc_miss || free_end) begin
          state_nxt = aba_pkg::ST_DONE;
        end
      end
      aba_pkg::ST_MARK: begin
        if (addr_r == mark_end_r) begin
          state_nxt = aba_pkg::ST_DONE;
        end
      end
      aba_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = aba_pkg::ST_IDLE;
        end
      end
      default: state_nxt = aba_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Outputs: memory controls and register next values
  // --------------------------------------------------------------------------
  always_comb begin
    cmd_nxt       = cmd_r;
    k_nxt         = k_r;
    idx_nxt       = idx_r;
    iss_nxt       = iss_r;
    dword_nxt     = WADDR_W'(iss_r);
    run_ok_nxt    = run_ok_r;
    gstart_nxt    = gstart_r;
    addr_nxt      = addr_r;
    mark_end_nxt  = mark_end_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    wr_en         = 1'b0;
    wr_addr       = dword_r;
    wr_data       = free_word;
    rd_en         = 1'b0;

    unique case (state_r)
      aba_pkg::ST_CLEAR: begin
        // sweep the map to unused, one word a cycle
        wr_en    = 1'b1;
        wr_addr  = addr_r;
        wr_data  = '0;
        addr_nxt = addr_r + WADDR_W'(1);
      end
      aba_pkg::ST_IDLE: begin
        if (in_acc) begin
          cmd_nxt    = in_data.cmd;
          k_nxt      = k_in;
          idx_nxt    = in_data.slot_index;
          run_ok_nxt = 1'b0;
          iss_nxt    = (in_data.cmd == aba_pkg::CMD_ALLOC) ? '0 :
                       WCNT_W'(in_data.slot_index >> WS_LOG);
          res_nxt    = '{status: aba_pkg::STATUS_FAIL, result_index: '0};
        end
      end
      aba_pkg::ST_SCAN: begin
        // stream reads ahead; a later word is never written before it is read
        rd_en = iss_r < WCNT_W'(NUM_WORDS);
        if (rd_en) begin
          iss_nxt = iss_r + WCNT_W'(1);
        end
        if (proc && (cmd_r == aba_pkg::CMD_ALLOC) && !is_small) begin
          run_ok_nxt = run_ok_now;
          gstart_nxt = gstart_now;
        end
        if (small_found) begin
          wr_en   = 1'b1;
          wr_data = alloc_word;
          res_nxt = '{status: aba_pkg::STATUS_OK,
                      result_index: IDX_W'({dword_r, j0})};
        end
        if (big_found) begin
          addr_nxt     = gstart_now;
          mark_end_nxt = dword_r;
          res_nxt      = '{status: aba_pkg::STATUS_OK,
                           result_index: IDX_W'({gstart_now, WS_LOG'(0)})};
        end
        if (alloc_miss) begin
          res_nxt = '{status: aba_pkg::STATUS_FAIL, result_index: '0};
        end
        if (proc && (cmd_r == aba_pkg::CMD_FREE)) begin
          wr_en = 1'b1;
        end
        if (free_end) begin
          res_nxt = '{status: aba_pkg::STATUS_OK, result_index: idx_r};
        end
      end
      aba_pkg::ST_MARK: begin
        // head word gets the start code, the rest of the run continue codes
        wr_en    = 1'b1;
        wr_addr  = addr_r;
        wr_data  = (addr_r == gstart_r) ? WORD_HEAD : WORD_CONT;
        addr_nxt = addr_r + WADDR_W'(1);
      end
      aba_pkg::ST_DONE: begin
        if (out_free) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign dvld_nxt = rd_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= aba_pkg::ST_CLEAR;
      addr_r      <= '0;
      dvld_r      <= 1'b0;
      out_valid_r <= 1'b0;
      run_ok_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      dvld_r      <= dvld_nxt;
      out_valid_r <= out_valid_nxt;
      run_ok_r    <= run_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    k_r        <= k_nxt;
    idx_r      <= idx_nxt;
    iss_r      <= iss_nxt;
    dword_r    <= dword_nxt;
    gstart_r   <= gstart_nxt;
    mark_end_r <= mark_end_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = state_r == aba_pkg::ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == aba_pkg::ST_IDLE || state_r == aba_pkg::ST_DONE) |-> !wr_en)
    else $error("map written while no request is in work");

  a_mark_big_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == aba_pkg::ST_MARK) |->
      (cmd_r == aba_pkg::CMD_ALLOC) && (k_r > POS_W'(WS_LOG)))
    else $error("run write pass entered for a request that fits one word");

  a_fail_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status == aba_pkg::STATUS_FAIL) |->
      (out_data_r.result_index == '0))
    else $error("failed request carries a nonzero index");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == aba_pkg::ST_DONE)
    else $error("result word loaded outside the done state");

endmodule

// ===== hw/rtl/aba_ram.sv =====
// ----------------------------------------------------------------------------
// aba_ram: generic single-clock RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module aba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
